// File: sv/soc_acd_pkg.sv
`timescale 1ns / 1ps

package soc_acd_pkg;

   // window depth used when the top level is not overridden
   localparam int WINDOW_DEFAULT = 5;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int CSR_W     = 19;
   localparam int SUM_OUT_W = 19;
   localparam int MEAN_W    = 20;
   localparam int CSR_IDX_W = 2;

   // reset and substitution values
   localparam int unsigned RESET_SAMPLE = 50;
   localparam int unsigned DEFAULT_TEMP = 250;
   localparam int unsigned MIN_SUM_RESET = 50;
   localparam int unsigned THRESH_RESET  = 5;

   // saturation limits of the result fields
   localparam int unsigned MAX19 = 32'h0007_FFFF;
   localparam int unsigned MAX20 = 32'h000F_FFFF;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_MIN_CHARGE_SUM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;

   // packed stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;

endpackage

// File: sv/soc_average_cycle_detector_unit.sv
`timescale 1ns / 1ps

// State-of-charge cycle detector. Each request carries a charge sample, a
// temperature sample and a temperature-valid flag; the charge goes into a
// WINDOW-deep ring whose running sum is the filtered charge times WINDOW.
// Every request gives exactly one response: the new sum, a below-minimum flag,
// and, when the sum moved from the last recorded sum by more than the
// threshold register, a cycle event with depth, mean and temperature (these
// three read zero without an event). A request passes the input register, then
// the result register; one request is taken every cycle unless the response
// side stalls; ring, sum and recorded sum update in that single result stage.
// Write registers through the csr port only while idle (not enforced here).
module soc_average_cycle_detector_unit #(
   parameter int WINDOW = soc_acd_pkg::WINDOW_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: tdata from bit 0 = charge_sample, temp_sample; tuser = temp_ok
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [soc_acd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                  req_tuser,
   // response: tdata from bit 0 = charge_sum, cycle_depth, cycle_mean,
   // cycle_temp, below_min, zero fill; tuser = cycle_event
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [soc_acd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                  rsp_tuser,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [soc_acd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [soc_acd_pkg::CSR_W-1:0]         csr_data
);

   localparam int SW    = soc_acd_pkg::SAMPLE_W;
   localparam int SUM_W = $clog2(WINDOW * ((1 << SW) - 1) + 1);
   localparam int EXT_W = (SUM_W + 1 > soc_acd_pkg::MEAN_W) ? SUM_W + 1
                                                             : soc_acd_pkg::MEAN_W;
   localparam int PTR_W = $clog2(WINDOW);
   localparam int RW    = soc_acd_pkg::SUM_OUT_W;
   localparam int MW    = soc_acd_pkg::MEAN_W;
   localparam int PAD_W = soc_acd_pkg::RSP_DATA_W - (2 * RW + MW + SW + 1);

   // configuration registers
   logic [soc_acd_pkg::CSR_W-1:0] min_sum_ff, min_sum_in;
   logic [soc_acd_pkg::CSR_W-1:0] thresh_ff, thresh_in;

   // input register
   logic          s1_valid_ff, s1_valid_in;
   logic [SW-1:0] s1_charge_ff, s1_charge_in;
   logic [SW-1:0] s1_temp_ff, s1_temp_in;

   // filter state
   logic [SW-1:0]    ring_ff [WINDOW];
   logic [SW-1:0]    ring_in [WINDOW];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] rec_ff, rec_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [soc_acd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                               rsp_event_ff, rsp_event_in;

   // datapath
   logic             out_advance;
   logic             s1_fire;
   logic             req_fire;
   logic [SUM_W-1:0] sum_new;
   logic [SUM_W-1:0] depth;
   logic             cycle_event;
   logic [EXT_W-1:0] sum_ext;
   logic [EXT_W-1:0] depth_ext;
   logic [EXT_W-1:0] mean_ext;
   logic [RW-1:0]    sum_sat;
   logic [RW-1:0]    depth_sat;
   logic [MW-1:0]    mean_sat;
   logic             below_min;

   // handshake
   assign out_advance = !rsp_valid_ff || rsp_tready;
   assign s1_fire     = s1_valid_ff && out_advance;
   assign req_tready  = !s1_valid_ff || out_advance;
   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   // register writes, out-of-map index ignored
   always_comb begin
      min_sum_in = min_sum_ff;
      thresh_in  = thresh_ff;
      if (csr_valid) begin
         case (csr_index)
            soc_acd_pkg::REG_MIN_CHARGE_SUM:   min_sum_in = csr_data;
            soc_acd_pkg::REG_CHANGE_THRESHOLD: thresh_in  = csr_data;
            default: ;
         endcase
      end
   end

   // input stage, failed temperature read replaced here
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_charge_in = s1_charge_ff;
      s1_temp_in   = s1_temp_ff;
      if (req_fire) begin
         s1_valid_in  = 1'b1;
         s1_charge_in = req_tdata[SW-1:0];
         s1_temp_in   = req_tuser ? req_tdata[2*SW-1:SW]
                                  : SW'(soc_acd_pkg::DEFAULT_TEMP);
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // running sum and change detection
   always_comb begin
      sum_new = sum_ff - SUM_W'(ring_ff[ptr_ff]) + SUM_W'(s1_charge_ff);
      depth   = (sum_new >= rec_ff) ? sum_new - rec_ff : rec_ff - sum_new;
      sum_ext   = EXT_W'(sum_new);
      depth_ext = EXT_W'(depth);
      mean_ext  = EXT_W'(sum_new) + EXT_W'(rec_ff);
      cycle_event = depth_ext > EXT_W'(thresh_ff);
      below_min   = sum_ext < EXT_W'(min_sum_ff);
      sum_sat   = (sum_ext > EXT_W'(soc_acd_pkg::MAX19)) ? RW'(soc_acd_pkg::MAX19)
                                                         : sum_ext[RW-1:0];
      depth_sat = (depth_ext > EXT_W'(soc_acd_pkg::MAX19)) ? RW'(soc_acd_pkg::MAX19)
                                                           : depth_ext[RW-1:0];
      mean_sat  = (mean_ext > EXT_W'(soc_acd_pkg::MAX20)) ? MW'(soc_acd_pkg::MAX20)
                                                          : mean_ext[MW-1:0];
   end

   // state update on each request leaving the input stage
   always_comb begin
      ring_in = ring_ff;
      ptr_in  = ptr_ff;
      sum_in  = sum_ff;
      rec_in  = rec_ff;
      if (s1_fire) begin
         ring_in[ptr_ff] = s1_charge_ff;
         ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
         sum_in = sum_new;
         if (cycle_event) begin
            rec_in = sum_new;
         end
      end
   end

   // result stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_event_in = rsp_event_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = cycle_event;
         rsp_data_in  = {PAD_W'(0), below_min,
                         cycle_event ? s1_temp_ff : SW'(0),
                         cycle_event ? mean_sat : MW'(0),
                         cycle_event ? depth_sat : RW'(0),
                         sum_sat};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_sum_ff   <= soc_acd_pkg::CSR_W'(soc_acd_pkg::MIN_SUM_RESET);
         thresh_ff    <= soc_acd_pkg::CSR_W'(soc_acd_pkg::THRESH_RESET);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= SW'(soc_acd_pkg::RESET_SAMPLE);
         end
         ptr_ff <= '0;
         sum_ff <= SUM_W'(soc_acd_pkg::RESET_SAMPLE * WINDOW);
         rec_ff <= SUM_W'(soc_acd_pkg::RESET_SAMPLE * WINDOW);
      end else begin
         min_sum_ff   <= min_sum_in;
         thresh_ff    <= thresh_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_ff      <= ring_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         rec_ff       <= rec_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_charge_ff <= s1_charge_in;
      s1_temp_ff   <= s1_temp_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_event_ff <= rsp_event_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_event_ff;

   // write pointer stays inside the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(WINDOW - 1))
      else $error("ring pointer out of range");

   // an event moves the recorded sum to the new window sum
   a_rec_update: assert property (@(posedge clock) disable iff (reset)
      s1_fire && cycle_event |=> rec_ff == sum_ff)
      else $error("recorded sum not updated on event");

   // without an event the recorded sum holds
   a_rec_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_fire && cycle_event) |=> $stable(rec_ff))
      else $error("recorded sum changed without event");

   // back pressure only when both stages are full
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free stage");

   // cycle fields are zero when no event is reported
   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[2*RW+MW+SW-1:RW] == '0)
      else $error("cycle fields set without event");

endmodule

// File: tb/soc_acd_checker.sv
`timescale 1ns / 1ps

// watches the request, response and register channels of the cycle detector,
// keeps its own copy of the charge window and registers, and compares every
// response against the oldest predicted report
module soc_acd_checker #(
   parameter int WINDOW = soc_acd_pkg::WINDOW_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [soc_acd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [soc_acd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [soc_acd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [soc_acd_pkg::CSR_W-1:0]      csr_data,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 sample_count,
   output int                                 event_count
);

   import soc_acd_pkg::*;

   // response field positions, lowest bit up
   localparam int DEPTH_LSB = SUM_OUT_W;
   localparam int MEAN_LSB  = DEPTH_LSB + SUM_OUT_W;
   localparam int TEMP_LSB  = MEAN_LSB + MEAN_W;
   localparam int BELOW_BIT = TEMP_LSB + SAMPLE_W;

   typedef struct {
      logic [SUM_OUT_W-1:0] charge_sum;
      logic                 cycle_event;
      logic [SUM_OUT_W-1:0] cycle_depth;
      logic [MEAN_W-1:0]    cycle_mean;
      logic [SAMPLE_W-1:0]  cycle_temp;
      logic                 below_min;
   } detector_report_type;

   // predicted detector state
   logic [SAMPLE_W-1:0] charge_ring [WINDOW];
   int unsigned         ring_slot;
   int unsigned         window_total;
   int unsigned         recorded_total;
   logic [CSR_W-1:0]    min_sum_reg;
   logic [CSR_W-1:0]    thresh_reg;

   detector_report_type predicted_reports [$];

   function automatic int unsigned clip(input int unsigned v, input int unsigned cap);
      return (v > cap) ? cap : v;
   endfunction

   task automatic note_mismatch(input string what, input int unsigned seen,
                                input int unsigned wanted);
      $display("mismatch on response %0d: %s got %0d expected %0d",
               sample_count, what, seen, wanted);
      fail_count++;
   endtask

   // push one charge sample through the window and predict its report
   task automatic fold_sample(input logic [SAMPLE_W-1:0] charge,
                              input logic [SAMPLE_W-1:0] temp_in,
                              input logic temp_valid);
      detector_report_type r;
      int unsigned         prev;
      int unsigned         depth;
      if (ring_slot >= WINDOW) ring_slot = 0;
      window_total = window_total - charge_ring[ring_slot] + charge;
      charge_ring[ring_slot] = charge;
      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;

      prev  = recorded_total;
      depth = (window_total >= prev) ? window_total - prev : prev - window_total;
      r.charge_sum  = SUM_OUT_W'(clip(window_total, MAX19));
      r.cycle_event = depth > thresh_reg;
      if (r.cycle_event) begin
         r.cycle_depth  = SUM_OUT_W'(clip(depth, MAX19));
         r.cycle_mean   = MEAN_W'(clip(window_total + prev, MAX20));
         // a failed temperature read reports room temperature
         r.cycle_temp   = temp_valid ? temp_in : SAMPLE_W'(DEFAULT_TEMP);
         recorded_total = window_total;
      end else begin
         r.cycle_depth = '0;
         r.cycle_mean  = '0;
         r.cycle_temp  = '0;
      end
      r.below_min = window_total < min_sum_reg;
      predicted_reports.push_back(r);
   endtask

   // compare one accepted response with the oldest prediction
   task automatic check_report();
      detector_report_type want;
      if (predicted_reports.size() == 0) begin
         note_mismatch("response with nothing outstanding, charge_sum",
                       rsp_tdata[SUM_OUT_W-1:0], 0);
      end else begin
         want = predicted_reports.pop_front();
         if (want.cycle_event) event_count++;
         if (rsp_tdata[SUM_OUT_W-1:0] !== want.charge_sum)
            note_mismatch("charge_sum", rsp_tdata[SUM_OUT_W-1:0], want.charge_sum);
         if (rsp_tuser !== want.cycle_event)
            note_mismatch("cycle_event", rsp_tuser, want.cycle_event);
         if (rsp_tdata[DEPTH_LSB +: SUM_OUT_W] !== want.cycle_depth)
            note_mismatch("cycle_depth", rsp_tdata[DEPTH_LSB +: SUM_OUT_W],
                          want.cycle_depth);
         if (rsp_tdata[MEAN_LSB +: MEAN_W] !== want.cycle_mean)
            note_mismatch("cycle_mean", rsp_tdata[MEAN_LSB +: MEAN_W], want.cycle_mean);
         if (rsp_tdata[TEMP_LSB +: SAMPLE_W] !== want.cycle_temp)
            note_mismatch("cycle_temp", rsp_tdata[TEMP_LSB +: SAMPLE_W], want.cycle_temp);
         if (rsp_tdata[BELOW_BIT] !== want.below_min)
            note_mismatch("below_min", rsp_tdata[BELOW_BIT], want.below_min);
      end
      sample_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) charge_ring[i] = SAMPLE_W'(RESET_SAMPLE);
         ring_slot      = 0;
         window_total   = RESET_SAMPLE * WINDOW;
         recorded_total = RESET_SAMPLE * WINDOW;
         min_sum_reg    = CSR_W'(MIN_SUM_RESET);
         thresh_reg     = CSR_W'(THRESH_RESET);
         predicted_reports.delete();
         fail_count   = 0;
         sample_count = 0;
         event_count  = 0;
      end else begin
         // older responses first, then the new request, then register writes
         if (rsp_tvalid && rsp_tready) check_report();
         if (req_tvalid && req_tready)
            fold_sample(req_tdata[SAMPLE_W-1:0], req_tdata[SAMPLE_W +: SAMPLE_W], req_tuser);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MIN_CHARGE_SUM:   min_sum_reg = csr_data;
               REG_CHANGE_THRESHOLD: thresh_reg  = csr_data;
               default: ;
            endcase
         end
      end
      pending = predicted_reports.size();
   end

endmodule

// File: tb/tb_soc_average_cycle_detector_unit.sv
`timescale 1ns / 1ps

module tb_soc_average_cycle_detector_unit;

   import soc_acd_pkg::*;

   localparam int WINDOW      = WINDOW_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 150;

   // register indexes outside the map, written to check they are ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // request: charge_sample [15:0], temp_sample [31:16]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // request tuser: temp_ok
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // response: charge_sum, cycle_depth, cycle_mean, cycle_temp, below_min, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // response tuser: cycle_event
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_data = '0;

   int   fail_count;
   int   pending;
   int   sample_count;
   int   event_count;
   int   cycle_count = 0;
   logic steady = 1'b0;

   // register settings per phase, extremes included; the last one is drawn at random
   int unsigned min_plan    [PHASES] = '{0, 50, 250, 1000, 524287, 327675, 400, 0};
   int unsigned thresh_plan [PHASES] = '{0, 5, 20, 60, 200, 524287, 327675, 0};

   always #1 clock = ~clock;

   soc_average_cycle_detector_unit #(.WINDOW(WINDOW)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   soc_acd_checker #(.WINDOW(WINDOW)) scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .sample_count (sample_count),
      .event_count  (event_count)
   );

   // response backpressure, off during the steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 16);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending);
         $display("tb_soc_average_cycle_detector_unit NOT OK");
         $finish;
      end
   end

   // one request, with a random gap ahead of it; entered and left at a falling edge
   task automatic send_sample(input logic [SAMPLE_W-1:0] charge,
                              input logic [SAMPLE_W-1:0] temp,
                              input logic temp_ok);
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {temp, charge};
      req_tuser  <= temp_ok;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending and let every outstanding response come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int              level;
      int unsigned     roll;
      logic [SAMPLE_W-1:0] charge;
      logic [SAMPLE_W-1:0] temp;
      logic            temp_ok;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset register values (minimum 50, threshold 5)
      send_sample(16'd50, 16'd300, 1'b1);      // unchanged sum, no event
      send_sample(16'd55, 16'hFFFF, 1'b0);     // change equal to threshold, no event
      send_sample(16'd51, 16'hFFFF, 1'b0);     // just over threshold, failed read
      send_sample(16'd0, 16'd0, 1'b1);         // falling sum, coldest temperature
      send_sample(16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(16'hFFFF, 16'hAAAA, 1'b1);
      send_sample(16'hFFFF, 16'h5555, 1'b1);
      send_sample(16'hFFFF, 16'd0, 1'b0);
      send_sample(16'hFFFF, 16'd250, 1'b1);    // full window of maximum samples
      send_sample(16'd0, 16'h5555, 1'b1);
      send_sample(16'd0, 16'hAAAA, 1'b0);
      send_sample(16'd0, 16'd1, 1'b1);
      send_sample(16'd0, 16'h8000, 1'b1);
      send_sample(16'd0, 16'h7FFF, 1'b1);      // empty window, below minimum
      send_sample(16'd10, 16'd400, 1'b1);      // sum 10, below minimum
      send_sample(16'd40, 16'd400, 1'b1);      // sum exactly at minimum
      send_sample(16'd100, 16'd400, 1'b0);
      send_sample(16'd100, 16'd400, 1'b1);
      drain();

      // random phases: mostly slowly drifting charge readings, some wild ones
      level = 50;
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            min_plan[p]    = $urandom_range(0, 600);
            thresh_plan[p] = $urandom_range(0, 100);
         end
         write_csr(REG_MIN_CHARGE_SUM, CSR_W'(min_plan[p]));
         write_csr(REG_CHANGE_THRESHOLD, CSR_W'(thresh_plan[p]));
         // spare indexes must not disturb the real registers
         write_csr(REG_SPARE_2, CSR_W'($urandom_range(0, MAX19)));
         write_csr(REG_SPARE_3, CSR_W'($urandom_range(0, MAX19)));
         steady <= (p == 1);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               if ($urandom_range(0, 99) < 5) level = $urandom_range(0, 100);
               else level = level + int'($urandom_range(0, 16)) - 8;
               if (level < 0) level = 0;
               if (level > 100) level = 100;
               charge = SAMPLE_W'(level);
            end else if (roll < 80) begin
               charge = SAMPLE_W'($urandom_range(0, 65535));
            end else if (roll < 90) begin
               charge = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
               charge = SAMPLE_W'($urandom_range(0, 100));
            end
            temp    = ($urandom_range(0, 99) < 70) ? SAMPLE_W'($urandom_range(0, 600))
                                                   : SAMPLE_W'($urandom_range(0, 65535));
            temp_ok = $urandom_range(0, 99) < 85;
            send_sample(charge, temp, temp_ok);
         end
         drain();
      end

      $display("checked %0d charge samples, %0d of them cycle events,", sample_count,
               event_count);
      $display("over the reset register values and %0d further settings", PHASES);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_soc_average_cycle_detector_unit OK");
      end else begin
         $display("tb_soc_average_cycle_detector_unit NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
sv/soc_acd_pkg.sv
sv/soc_average_cycle_detector_unit.sv
tb/soc_acd_checker.sv
tb/tb_soc_average_cycle_detector_unit.sv
